[sv/scan_disk_request_scheduler_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the SCAN disk request scheduler
// Shared helpers that keep clocking and reset handling uniform.
// ----------------------------------------------------------------------------
`ifndef SCAN_DISK_REQUEST_SCHEDULER_MACROS_SVH
`define SCAN_DISK_REQUEST_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SDRS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SDRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/sdrs_pkg.sv]
// ----------------------------------------------------------------------------
// sdrs_pkg
// Widths, codes and controller/datapath interface types for the scheduler.
// ----------------------------------------------------------------------------
package sdrs_pkg;

	localparam int SECTOR_W = 16;
	localparam int TAG_W    = 8;
	localparam int CYL_W    = 11;
	localparam int DIST_W   = 12;
	localparam int DIR_W    = 2;
	localparam int ACC_W    = 32;

	localparam logic [CYL_W-1:0]     CYL_MAX   = 11'd2047;
	localparam logic [DIST_W-1:0]    BEST_NONE = 12'hFFF;

	// Operation codes
	localparam logic OP_SUBMIT   = 1'b0;
	localparam logic OP_COMPLETE = 1'b1;

	// Seek direction codes
	localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
	localparam logic [DIR_W-1:0] DIR_IN   = 2'd1;
	localparam logic [DIR_W-1:0] DIR_OUT  = 2'd2;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic div_step;
		logic submit;
		logic nop;
		logic svc_read;
		logic take_head;
		logic shift;
		logic cend;
		logic scan;
		logic pick;
		logic grant;
		logic load_out;
	} sdrs_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic is_submit;
		logic busy;
		logic shift_first;
		logic shift_more;
		logic last_entry;
		logic scan_last;
		logic out_free;
	} sdrs_sts_t;

endpackage

[sv/sdrs_ctrl.sv]
// ----------------------------------------------------------------------------
// sdrs_ctrl
// Sequencer for divide, enqueue, remove/compact, scan and grant phases.
// ----------------------------------------------------------------------------
module sdrs_ctrl
	import sdrs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  sdrs_sts_t sts,
	output sdrs_cmd_t cmd
);

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_DISP   = 13'b0000000000010,
		S_DIV    = 13'b0000000000100,
		S_SUBMIT = 13'b0000000001000,
		S_NOP    = 13'b0000000010000,
		S_CREAD  = 13'b0000000100000,
		S_CHEAD  = 13'b0000001000000,
		S_SHIFT  = 13'b0000010000000,
		S_CEND   = 13'b0000100000000,
		S_SCAN   = 13'b0001000000000,
		S_PICK   = 13'b0010000000000,
		S_GRANT  = 13'b0100000000000,
		S_OUT    = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) state_d = S_DISP;
			end
			S_DISP: begin
				if (sts.is_submit)  state_d = S_DIV;
				else if (sts.busy)  state_d = S_CREAD;
				else                state_d = S_NOP;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				state_d      = S_SUBMIT;
			end
			S_SUBMIT: begin
				cmd.submit = 1'b1;
				state_d    = S_OUT;
			end
			S_NOP: begin
				cmd.nop = 1'b1;
				state_d = S_OUT;
			end
			S_CREAD: begin
				cmd.svc_read = 1'b1;
				state_d      = S_CHEAD;
			end
			S_CHEAD: begin
				cmd.take_head = 1'b1;
				state_d       = sts.shift_first ? S_SHIFT : S_CEND;
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				state_d   = sts.shift_more ? S_SHIFT : S_CEND;
			end
			S_CEND: begin
				cmd.cend = 1'b1;
				state_d  = sts.last_entry ? S_OUT : S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) state_d = S_PICK;
			end
			S_PICK: begin
				cmd.pick = 1'b1;
				state_d  = S_GRANT;
			end
			S_GRANT: begin
				cmd.grant = 1'b1;
				state_d   = S_OUT;
			end
			S_OUT: begin
				cmd.load_out = sts.out_free;
				if (sts.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[sv/sdrs_datapath.sv]
// ----------------------------------------------------------------------------
// sdrs_datapath
// Cylinder divider, request table memory, scan trackers, statistics and
// the output register.
// ----------------------------------------------------------------------------
module sdrs_datapath
	import sdrs_pkg::*;
#(
	parameter int QUEUE_DEPTH          = 16,
	parameter int SECTORS_PER_CYLINDER = 36
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sdrs_cmd_t                cmd,
	output sdrs_sts_t                sts,
	input  logic                     op,
	input  logic [SECTOR_W-1:0]      sector,
	input  logic [TAG_W-1:0]         tag,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     grant_valid,
	output logic [TAG_W-1:0]         grant_tag,
	output logic [CYL_W-1:0]         grant_cylinder,
	output logic signed [DIST_W-1:0] seek_distance,
	output logic [DIR_W-1:0]         seek_direction,
	output logic                     rejected,
	output logic                     queue_empty,
	output logic [ACC_W-1:0]         total_seek,
	output logic [ACC_W-1:0]         total_grants
);

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int PW = CW + 1;
	localparam int EW = CYL_W + TAG_W;
	localparam int RECIP_SH = 32;
	localparam int PROD_W   = SECTOR_W + RECIP_SH;
	// Rounded-up reciprocal: exact quotient for every 16-bit sector
	localparam logic [RECIP_SH:0] RECIP = (RECIP_SH+1)'(
		((64'd1 << RECIP_SH) + 64'(SECTORS_PER_CYLINDER) - 64'd1)
		/ 64'(SECTORS_PER_CYLINDER));
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	// Captured item
	logic                op_q;
	logic [TAG_W-1:0]    tag_q;

	// Divider
	logic [SECTOR_W-1:0]  num_q, quo_q;
	logic [PROD_W-1:0]    prod;
	logic [CYL_W-1:0]     cyl_sat;

	// Table and scheduler state
	logic [EW-1:0]     mem [QUEUE_DEPTH];
	logic [EW-1:0]     rd_q;
	logic [IW-1:0]     rd_addr;
	logic              we;
	logic [IW-1:0]     wr_addr;
	logic [EW-1:0]     wr_data;
	logic [CW-1:0]     count_q;
	logic [IW-1:0]     svc_q, ptr_q, svc_idx;
	logic              busy_q, inward_q, cont_q;
	logic [CYL_W-1:0]  head_q;
	logic [ACC_W-1:0]  run_seek_q, run_grants_q, lat_seek_q, lat_grants_q;

	// Scan trackers
	logic              eq_found_q;
	logic [IW-1:0]     eq_pick_q, in_pick_q, out_pick_q, pick_idx;
	logic [DIST_W-1:0] in_best_q, out_best_q;
	logic              in_found, out_found;
	logic [CYL_W-1:0]  rd_cyl;
	logic [TAG_W-1:0]  rd_tag;
	logic [DIST_W-1:0] scan_d_in, scan_d_out;

	// Grant arithmetic
	logic [CYL_W-1:0]  g_cyl, g_mag;
	logic [TAG_W-1:0]  g_tag;
	logic [DIST_W-1:0] g_dist;
	logic [DIR_W-1:0]  g_dir;
	logic              grant_fire;

	// Pending result
	logic              res_grant_q, res_rej_q;
	logic [TAG_W-1:0]  res_tag_q;
	logic [CYL_W-1:0]  res_cyl_q;
	logic [DIST_W-1:0] res_dist_q;
	logic [DIR_W-1:0]  res_dir_q;
	logic              out_valid_q;

	// Divide by reciprocal multiplication, saturate to the cylinder width
	assign prod    = PROD_W'(num_q) * PROD_W'(RECIP);
	assign cyl_sat = (|quo_q[SECTOR_W-1:CYL_W]) ? CYL_MAX : quo_q[CYL_W-1:0];

	assign rd_cyl = rd_q[EW-1:TAG_W];
	assign rd_tag = rd_q[TAG_W-1:0];

	// Service index falls back to entry zero when out of range
	assign svc_idx = ({{(PW-IW){1'b0}}, svc_q} < {1'b0, count_q}) ? svc_q : '0;

	// Direction choice over the scan trackers
	assign in_found  = (in_best_q != BEST_NONE);
	assign out_found = (out_best_q != BEST_NONE);
	always_comb begin
		if (eq_found_q)    pick_idx = eq_pick_q;
		else if (inward_q) pick_idx = in_found ? in_pick_q : out_pick_q;
		else               pick_idx = out_found ? out_pick_q : in_pick_q;
	end

	// Read address select
	always_comb begin
		if (cmd.svc_read)   rd_addr = svc_idx;
		else if (cmd.cend)  rd_addr = '0;
		else if (cmd.shift) rd_addr = IW'(ptr_q + IW'(2));
		else if (cmd.pick)  rd_addr = pick_idx;
		else                rd_addr = IW'(ptr_q + IW'(1));
	end

	// Write port select
	always_comb begin
		we      = 1'b0;
		wr_addr = ptr_q;
		wr_data = rd_q;
		if (cmd.shift) begin
			we = 1'b1;
		end else if (cmd.submit) begin
			wr_data = {cyl_sat, tag_q};
			if (!busy_q) begin
				we      = 1'b1;
				wr_addr = '0;
			end else if (count_q < DEPTH_C) begin
				we      = 1'b1;
				wr_addr = count_q[IW-1:0];
			end
		end
	end

	// Table memory, registered read
	always_ff @(posedge clk) begin
		if (we) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// Grant values
	assign g_cyl  = cmd.grant ? rd_cyl : cyl_sat;
	assign g_tag  = cmd.grant ? rd_tag : tag_q;
	assign g_dist = {1'b0, g_cyl} - {1'b0, head_q};
	assign g_mag  = (g_cyl >= head_q) ? (g_cyl - head_q) : (head_q - g_cyl);
	assign g_dir  = (g_cyl > head_q) ? DIR_IN : ((g_cyl < head_q) ? DIR_OUT : DIR_NONE);
	assign grant_fire = cmd.grant || (cmd.submit && !busy_q);

	assign scan_d_in  = {1'b0, rd_cyl - head_q};
	assign scan_d_out = {1'b0, head_q - rd_cyl};

	// Captured item and quotient register
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= op;
			tag_q <= tag;
			num_q <= sector;
		end else if (cmd.div_step) begin
			quo_q <= prod[PROD_W-1:RECIP_SH];
		end
	end

	// Scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			svc_q        <= '0;
			busy_q       <= 1'b0;
			head_q       <= '0;
			inward_q     <= 1'b1;
			cont_q       <= 1'b0;
			run_seek_q   <= '0;
			run_grants_q <= '0;
			lat_seek_q   <= '0;
			lat_grants_q <= '0;
			ptr_q        <= '0;
		end else begin
			// Enqueue or grant at once
			if (cmd.submit) begin
				if (!busy_q) begin
					count_q <= ONE_C;
					svc_q   <= '0;
					busy_q  <= 1'b1;
				end else if (count_q < DEPTH_C) begin
					count_q <= count_q + ONE_C;
					cont_q  <= 1'b1;
				end
			end
			// Remove serviced entry and close the gap
			if (cmd.svc_read)  ptr_q  <= svc_idx;
			if (cmd.take_head) head_q <= rd_cyl;
			if (cmd.shift)     ptr_q  <= IW'(ptr_q + IW'(1));
			if (cmd.cend) begin
				count_q <= count_q - ONE_C;
				ptr_q   <= '0;
				if (count_q == ONE_C) begin
					busy_q       <= 1'b0;
					svc_q        <= '0;
					lat_seek_q   <= run_seek_q;
					lat_grants_q <= run_grants_q;
					if (cont_q) begin
						cont_q       <= 1'b0;
						run_seek_q   <= '0;
						run_grants_q <= '0;
					end
				end
			end
			if (cmd.scan) ptr_q <= IW'(ptr_q + IW'(1));
			// Select next request, reverse when the sweep runs dry
			if (cmd.pick) begin
				svc_q <= pick_idx;
				if (!eq_found_q) begin
					if (inward_q && !in_found)       inward_q <= 1'b0;
					else if (!inward_q && !out_found) inward_q <= 1'b1;
				end
			end
			// Count contended grants
			if (grant_fire && cont_q) begin
				run_seek_q   <= run_seek_q + ACC_W'(g_mag);
				run_grants_q <= run_grants_q + ACC_W'(1);
			end
		end
	end

	// Scan trackers: earliest exact hit, nearest on each side
	always_ff @(posedge clk) begin
		if (cmd.cend) begin
			eq_found_q <= 1'b0;
			eq_pick_q  <= '0;
			in_best_q  <= BEST_NONE;
			in_pick_q  <= '0;
			out_best_q <= BEST_NONE;
			out_pick_q <= '0;
		end else if (cmd.scan) begin
			if (rd_cyl == head_q) begin
				if (!eq_found_q) begin
					eq_found_q <= 1'b1;
					eq_pick_q  <= ptr_q;
				end
			end else if (rd_cyl > head_q) begin
				if (scan_d_in < in_best_q) begin
					in_best_q <= scan_d_in;
					in_pick_q <= ptr_q;
				end
			end else if (scan_d_out < out_best_q) begin
				out_best_q <= scan_d_out;
				out_pick_q <= ptr_q;
			end
		end
	end

	// Pending result fields
	always_ff @(posedge clk) begin
		if (grant_fire) begin
			res_grant_q <= 1'b1;
			res_tag_q   <= g_tag;
			res_cyl_q   <= g_cyl;
			res_dist_q  <= g_dist;
			res_dir_q   <= g_dir;
			res_rej_q   <= 1'b0;
		end else if (cmd.submit || cmd.nop || cmd.cend) begin
			res_grant_q <= 1'b0;
			res_tag_q   <= '0;
			res_cyl_q   <= '0;
			res_dist_q  <= '0;
			res_dir_q   <= DIR_NONE;
			res_rej_q   <= cmd.submit && (count_q >= DEPTH_C);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			grant_valid    <= res_grant_q;
			grant_tag      <= res_tag_q;
			grant_cylinder <= res_cyl_q;
			seek_distance  <= res_dist_q;
			seek_direction <= res_dir_q;
			rejected       <= res_rej_q;
			queue_empty    <= !busy_q;
			total_seek     <= lat_seek_q;
			total_grants   <= lat_grants_q;
		end
	end

	assign out_valid = out_valid_q;

	// Status to controller
	assign sts.is_submit   = (op_q == OP_SUBMIT);
	assign sts.busy        = busy_q;
	assign sts.shift_first = (PW'(ptr_q) + PW'(1)) < PW'(count_q);
	assign sts.shift_more  = (PW'(ptr_q) + PW'(2)) < PW'(count_q);
	assign sts.last_entry  = (count_q == ONE_C);
	assign sts.scan_last   = (PW'(ptr_q) + PW'(1)) >= PW'(count_q);
	assign sts.out_free    = !out_valid_q || out_ready;

endmodule

[sv/scan_disk_request_scheduler.sv]
// ----------------------------------------------------------------------------
// scan_disk_request_scheduler
// Elevator (SCAN) disk request arbiter with an arrival-ordered table.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   op, sector, tag
// out      output     out_valid / out_ready grant_valid, grant_tag, grant_cylinder,
//                                           seek_distance, seek_direction, rejected,
//                                           queue_empty, total_seek, total_grants
//
// One transaction at a time. On a submit the divide step scales the sector
// by the reciprocal of the sector count to derive the cylinder. In a
// completion, one memory read port shifts entries down one per cycle, then
// scans them one per cycle. in_ready is high only in the idle state; the
// result register holds a finished result until taken, so the next
// transaction may be accepted while it waits. Reset is asynchronous.
// ----------------------------------------------------------------------------
module scan_disk_request_scheduler
	import sdrs_pkg::*;
#(
	parameter int QUEUE_DEPTH          = 16,
	parameter int SECTORS_PER_CYLINDER = 36
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     op,
	input  logic [SECTOR_W-1:0]      sector,
	input  logic [TAG_W-1:0]         tag,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     grant_valid,
	output logic [TAG_W-1:0]         grant_tag,
	output logic [CYL_W-1:0]         grant_cylinder,
	output logic signed [DIST_W-1:0] seek_distance,
	output logic [DIR_W-1:0]         seek_direction,
	output logic                     rejected,
	output logic                     queue_empty,
	output logic [ACC_W-1:0]         total_seek,
	output logic [ACC_W-1:0]         total_grants
);

	sdrs_cmd_t cmd;
	sdrs_sts_t sts;

	// Sequencer
	sdrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Table, arithmetic and result register
	sdrs_datapath #(
		.QUEUE_DEPTH          (QUEUE_DEPTH),
		.SECTORS_PER_CYLINDER (SECTORS_PER_CYLINDER)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.op             (op),
		.sector         (sector),
		.tag            (tag),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.grant_valid    (grant_valid),
		.grant_tag      (grant_tag),
		.grant_cylinder (grant_cylinder),
		.seek_distance  (seek_distance),
		.seek_direction (seek_direction),
		.rejected       (rejected),
		.queue_empty    (queue_empty),
		.total_seek     (total_seek),
		.total_grants   (total_grants)
	);

	// Checks
	`include "scan_disk_request_scheduler_macros.svh"

	`SDRS_ASSERT_SAME(a_grant_not_rejected, clk, arst_n, out_valid && grant_valid, !rejected, "grant and reject together")
	`SDRS_ASSERT_SAME(a_grant_keeps_busy, clk, arst_n, out_valid && grant_valid, !queue_empty, "grant reported with empty queue")
	`SDRS_ASSERT_SAME(a_reject_when_busy, clk, arst_n, out_valid && rejected, !queue_empty, "reject reported while idle")
	`SDRS_ASSERT_SAME(a_still_zero_dist, clk, arst_n, out_valid && (seek_direction == DIR_NONE), seek_distance == '0, "no move with nonzero distance")

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives random and directed disk requests into the SCAN scheduler, tracks
// the request table and head position in a scoreboard, and checks each
// result transaction field by field.
// ----------------------------------------------------------------------------
class sched_scoreboard;
	logic [10:0] cyl_q[$];
	logic [7:0]  tag_q[$];
	int unsigned svc_idx;
	bit          busy;
	logic [10:0] head;
	bit          inward;
	bit          contention;
	logic [31:0] run_seek, run_grants, lat_seek, lat_grants;
	logic [99:0] grant_q[$];
	int          errors;

	function new();
		svc_idx = 0; busy = 0; head = 0; inward = 1; contention = 0;
		run_seek = 0; run_grants = 0; lat_seek = 0; lat_grants = 0; errors = 0;
	endfunction

	function int pending();
		return grant_q.size();
	endfunction

	function int fill();
		return cyl_q.size();
	endfunction

	// Note an accepted input and compute the expected result.
	function void note_request(logic op, logic [15:0] sector, logic [7:0] tag);
		logic [7:0]  gt;
		logic [10:0] gc;
		logic [11:0] gd;
		logic [1:0]  gdir;
		logic        gv, rej;
		int unsigned idx, pick, i;
		int unsigned cyl;
		logic [10:0] c, in_best, out_best;
		int          in_pick, out_pick;
		bit          found;
		gv = 0; gt = 0; gc = 0; gd = 0; gdir = 0; rej = 0; pick = 0;
		if (op == sdrs_pkg::OP_SUBMIT) begin
			cyl = sector / 36;
			if (cyl > 2047) cyl = 2047;
			if (!busy) begin
				cyl_q = {}; tag_q = {};
				cyl_q.push_back(11'(cyl)); tag_q.push_back(tag);
				svc_idx = 0; busy = 1; gv = 1; pick = 0;
			end else if (cyl_q.size() >= 16) begin
				rej = 1;
			end else begin
				cyl_q.push_back(11'(cyl)); tag_q.push_back(tag);
				contention = 1;
			end
		end else if (busy) begin
			idx = (svc_idx < cyl_q.size()) ? svc_idx : 0;
			head = cyl_q[idx];
			cyl_q.delete(idx); tag_q.delete(idx);
			if (cyl_q.size() == 0) begin
				busy = 0; svc_idx = 0;
				lat_seek = run_seek; lat_grants = run_grants;
				if (contention) begin
					contention = 0; run_seek = 0; run_grants = 0;
				end
			end else begin
				// pick same cylinder, else nearest in scan direction
				in_pick = -1; out_pick = -1; found = 0;
				in_best = 0; out_best = 0;
				for (i = 0; i < cyl_q.size() && !found; i++) begin
					c = cyl_q[i];
					if (c == head) begin
						pick = i; found = 1;
					end else if (c > head) begin
						if (in_pick < 0 || c - head < in_best) begin
							in_best = c - head; in_pick = i;
						end
					end else if (out_pick < 0 || head - c < out_best) begin
						out_best = head - c; out_pick = i;
					end
				end
				if (!found) begin
					if (inward) begin
						if (in_pick >= 0) pick = in_pick;
						else begin
							inward = 0; pick = out_pick;
						end
					end else if (out_pick >= 0) pick = out_pick;
					else begin
						inward = 1; pick = in_pick;
					end
				end
				svc_idx = pick; gv = 1;
			end
		end
		if (gv) begin
			gc = cyl_q[pick];
			gt = tag_q[pick];
			gd = {1'b0, gc} - {1'b0, head};
			gdir = (gc > head) ? sdrs_pkg::DIR_IN :
				(gc < head) ? sdrs_pkg::DIR_OUT : sdrs_pkg::DIR_NONE;
			if (contention) begin
				run_seek += (gc >= head) ? gc - head : head - gc;
				run_grants += 1;
			end
		end
		grant_q.push_back({gv, gt, gc, gd, gdir, rej, ~busy, lat_seek, lat_grants});
	endfunction

	// Compare one result transaction against the oldest expectation.
	function void check_result(logic [99:0] got);
		logic [99:0] exp_r;
		if (grant_q.size() == 0) begin
			$error("unexpected result transaction");
			errors++;
			return;
		end
		exp_r = grant_q.pop_front();
		cmp("grant_valid", exp_r[99], got[99]);
		cmp("grant_tag", exp_r[98:91], got[98:91]);
		cmp("grant_cylinder", exp_r[90:80], got[90:80]);
		cmp("seek_distance", exp_r[79:68], got[79:68]);
		cmp("seek_direction", exp_r[67:66], got[67:66]);
		cmp("rejected", exp_r[65], got[65]);
		cmp("queue_empty", exp_r[64], got[64]);
		cmp("total_seek", exp_r[63:32], got[63:32]);
		cmp("total_grants", exp_r[31:0], got[31:0]);
	endfunction

	function void cmp(string name, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$error("%s mismatch: expected %0d, actual %0d", name, e, a);
			errors++;
		end
	endfunction
endclass

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sdrs_pkg::*;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, op = 0, out_ready = 0;
	logic [15:0] sector = 0;
	logic [7:0]  tag = 0;
	logic in_ready, out_valid;
	logic grant_valid, rejected, queue_empty;
	logic [7:0]  grant_tag;
	logic [10:0] grant_cylinder;
	logic signed [11:0] seek_distance;
	logic [1:0]  seek_direction;
	logic [31:0] total_seek, total_grants;
	bit          stim_done = 0;
	int          rx_wait = 0;

	sched_scoreboard sb = new();

	scan_disk_request_scheduler DUT (.*);

	always #10 clk = ~clk;

	// Send one transaction after a random gap.
	task automatic send(logic o, logic [15:0] s, logic [7:0] t);
		int gap;
		gap = $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1; op <= o; sector <= s; tag <= t;
		do @(posedge clk); while (!in_ready);
		sb.note_request(o, s, t);
	endtask

	// Stop sending and wait until every expected result has come.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// Stimulus
	initial begin
		int n;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: idle completion, extremes, full table, rejects
		send(OP_COMPLETE, 16'hFFFF, 8'hFF);
		send(OP_SUBMIT, 16'h0000, 8'h00);
		send(OP_SUBMIT, 16'hFFFF, 8'hFF);
		send(OP_SUBMIT, 16'h0023, 8'hA5);
		send(OP_SUBMIT, 16'h0024, 8'h5A);
		for (int i = 0; i < 15; i++)
			send(OP_SUBMIT, 16'($urandom_range(0, 2000)), 8'(i));
		for (int i = 0; i < 18; i++)
			send(OP_COMPLETE, 16'h0000, 8'h00);
		settle();
		// random: even mix of submits and completions (submit when empty), drain to idle sometimes
		n = 0;
		while (n < 360) begin
			int burst;
			burst = $urandom_range(1, 20);
			for (int i = 0; i < burst; i++) begin
				logic o;
				o = (sb.fill() == 0) ? OP_SUBMIT : ($urandom_range(0, 99) < 50);
				send(o, 16'(($urandom_range(0, 3) == 0) ? $urandom() :
					$urandom_range(0, 1500)), 8'($urandom()));
				n++;
			end
			if ($urandom_range(0, 4) == 0) begin
				while (sb.fill() > 0) begin
					send(OP_COMPLETE, 16'($urandom()), 8'($urandom()));
					n++;
				end
				settle();
			end
		end
		while (sb.fill() > 0) send(OP_COMPLETE, 16'($urandom()), 8'($urandom()));
		in_valid <= 1'b0;
		stim_done = 1;
	end

	// Receiver: wait a drawn number of cycles before taking each result
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				sb.check_result({grant_valid, grant_tag, grant_cylinder, seek_distance,
					seek_direction, rejected, queue_empty, total_seek, total_grants});
				rx_wait = $urandom_range(0, 6);
				out_ready <= (rx_wait == 0);
			end else if (rx_wait > 0) begin
				rx_wait--;
				out_ready <= (rx_wait == 0);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// End of run
	initial begin
		wait (stim_done);
		while (sb.pending() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0)
			$display("scan_disk_request_scheduler regression: pass");
		else
			$display("scan_disk_request_scheduler regression: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("scan_disk_request_scheduler regression: fail");
		$finish;
	end
endmodule

[sim.f]
+incdir+sv
sv/sdrs_pkg.sv
sv/sdrs_ctrl.sv
sv/sdrs_datapath.sv
sv/scan_disk_request_scheduler.sv
sim/tb_top.sv
